// File: src/swta_pkg.sv
// Shared types, codes and constants for the stopwatch, timer and alarm unit.
package swta_pkg;

  localparam int RING_INTERVAL_DEF = 2;
  localparam int MINUTE_STEP       = 5;

  localparam int HOURS     = 24;
  localparam int MINS      = 60;
  localparam int SECS      = 60;
  localparam int SETUP_MIN = 1;
  localparam int SETUP_MAX = 99;
  localparam int SHOW_CAP  = 99;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_VIBE_KIND    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_REPEATS = 1'd1;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_UP     = 2'd1;
  localparam logic [1:0] CMD_DOWN   = 2'd2;
  localparam logic [1:0] CMD_SELECT = 2'd3;

  localparam logic [1:0] VIEW_WATCH = 2'd0;
  localparam logic [1:0] VIEW_TIMER = 2'd1;
  localparam logic [1:0] VIEW_ALARM = 2'd2;
  localparam logic [1:0] VIEW_NONE  = 2'd3;

  localparam logic [2:0] TITLE_WATCH = 3'd0;
  localparam logic [2:0] TITLE_TIMER = 3'd1;
  localparam logic [2:0] TITLE_ALARM = 3'd2;
  localparam logic [2:0] TITLE_STOP  = 3'd3;
  localparam logic [2:0] TITLE_ARMED = 3'd4;
  localparam logic [2:0] TITLE_NONE  = 3'd5;

  localparam logic [1:0] RING_NONE  = 2'd0;
  localparam logic [1:0] RING_TIMER = 2'd1;
  localparam logic [1:0] RING_ALARM = 2'd2;

  localparam logic [1:0] ALARM_EDIT_HOUR = 2'd0;
  localparam logic [1:0] ALARM_EDIT_MIN  = 2'd1;
  localparam logic [1:0] ALARM_ARMED     = 2'd2;

  localparam logic [1:0] VIBE_LONG  = 2'd1;
  localparam logic [1:0] VIBE_UNDEF = 2'd3;

  localparam logic [1:0] VIBE_KIND_RST    = 2'd1;
  localparam logic [3:0] RING_REPEATS_RST = 4'd10;
  localparam logic [6:0] SETUP_RST        = 7'd5;
  localparam logic [4:0] ALARM_HOUR_RST   = 5'd7;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] view;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
  } in_word_t;

  typedef struct packed {
    logic [6:0] show_left;
    logic [5:0] show_right;
    logic [2:0] title_code;
    logic       pulse;
    logic [1:0] pulse_kind;
    logic [1:0] ring_source;
  } out_word_t;

  typedef struct packed {
    logic [1:0] vibe_kind;
    logic [3:0] ring_repeats;
  } cfg_t;

endpackage

// File: src/swta_core.sv
// State of stopwatch, countdown, alarm and ring, and the result of one word.
module swta_core #(
  parameter int RING_INTERVAL_TICKS = swta_pkg::RING_INTERVAL_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  swta_pkg::in_word_t  item,
  input  swta_pkg::cfg_t      cfg,
  output swta_pkg::out_word_t result
);
  import swta_pkg::*;

  localparam int PHASE_W = $clog2(RING_INTERVAL_TICKS + 1);
  localparam int MIN_UP  = MINUTE_STEP % MINS;
  localparam int MIN_DN  = MINS - MIN_UP;

  logic               watch_run_r, watch_run_nxt;
  logic [31:0]        watch_cnt_r, watch_cnt_nxt;
  logic [5:0]         watch_sec_r, watch_sec_nxt;
  logic [6:0]         watch_min_r, watch_min_nxt;
  logic               cd_run_r, cd_run_nxt;
  logic [6:0]         cd_min_r, cd_min_nxt;
  logic [5:0]         cd_sec_r, cd_sec_nxt;
  logic [6:0]         setup_r, setup_nxt;
  logic [4:0]         alarm_hour_r, alarm_hour_nxt;
  logic [5:0]         alarm_min_r, alarm_min_nxt;
  logic [1:0]         alarm_mode_r, alarm_mode_nxt;
  logic [3:0]         ring_left_r, ring_left_nxt;
  logic [1:0]         ring_who_r, ring_who_nxt;
  logic [PHASE_W-1:0] ring_phase_r, ring_phase_nxt;

  logic               pulse;
  logic [PHASE_W-1:0] phase_inc;
  logic [6:0]         min_sum;

  always_comb begin
    watch_run_nxt  = watch_run_r;
    watch_cnt_nxt  = watch_cnt_r;
    watch_sec_nxt  = watch_sec_r;
    watch_min_nxt  = watch_min_r;
    cd_run_nxt     = cd_run_r;
    cd_min_nxt     = cd_min_r;
    cd_sec_nxt     = cd_sec_r;
    setup_nxt      = setup_r;
    alarm_hour_nxt = alarm_hour_r;
    alarm_min_nxt  = alarm_min_r;
    alarm_mode_nxt = alarm_mode_r;
    ring_left_nxt  = ring_left_r;
    ring_who_nxt   = ring_who_r;
    ring_phase_nxt = ring_phase_r;
    pulse          = 1'b0;
    phase_inc      = ring_phase_r + PHASE_W'(1);
    min_sum        = '0;

    priority if (item.cmd == CMD_TICK) begin
      if (watch_run_r) begin
        if (&watch_cnt_r) begin
          watch_cnt_nxt = '0;
          watch_sec_nxt = '0;
          watch_min_nxt = '0;
        end else begin
          watch_cnt_nxt = watch_cnt_r + 32'd1;
          if (watch_sec_r == 6'(SECS - 1)) begin
            watch_sec_nxt = '0;
            if (watch_min_r != 7'(SHOW_CAP)) watch_min_nxt = watch_min_r + 7'd1;
          end else begin
            watch_sec_nxt = watch_sec_r + 6'd1;
          end
        end
      end
      if (cd_run_r && (cd_min_r != '0 || cd_sec_r != '0)) begin
        if (cd_sec_r == '0) begin
          cd_sec_nxt = 6'(SECS - 1);
          cd_min_nxt = cd_min_r - 7'd1;
        end else begin
          cd_sec_nxt = cd_sec_r - 6'd1;
        end
      end
      if (ring_left_r != '0) begin
        if (phase_inc >= PHASE_W'(RING_INTERVAL_TICKS)) begin
          ring_phase_nxt = '0;
          pulse          = 1'b1;
          ring_left_nxt  = ring_left_r - 4'd1;
          if (ring_left_r == 4'd1) ring_who_nxt = RING_NONE;
        end else begin
          ring_phase_nxt = phase_inc;
        end
      end else begin
        if (cd_run_r && cd_min_nxt == '0 && cd_sec_nxt == '0) begin
          cd_run_nxt     = 1'b0;
          ring_left_nxt  = cfg.ring_repeats;
          ring_phase_nxt = '0;
          ring_who_nxt   = (cfg.ring_repeats != '0) ? RING_TIMER : RING_NONE;
          pulse          = 1'b1;
        end
        if (alarm_mode_r == ALARM_ARMED && item.clock_hour == alarm_hour_r &&
            item.clock_minute == alarm_min_r) begin
          alarm_mode_nxt = ALARM_EDIT_HOUR;
          ring_left_nxt  = cfg.ring_repeats;
          ring_phase_nxt = '0;
          ring_who_nxt   = (cfg.ring_repeats != '0) ? RING_ALARM : RING_NONE;
          pulse          = 1'b1;
        end
      end
    end else if (ring_left_r != '0 || ring_who_r != RING_NONE) begin
      ring_left_nxt  = '0;
      ring_who_nxt   = RING_NONE;
      ring_phase_nxt = '0;
    end else if (item.cmd == CMD_SELECT) begin
      unique case (item.view)
        VIEW_WATCH: watch_run_nxt = !watch_run_r;
        VIEW_TIMER: begin
          if (cd_run_r) begin
            cd_run_nxt = 1'b0;
            cd_min_nxt = '0;
            cd_sec_nxt = '0;
          end else begin
            cd_run_nxt = 1'b1;
            cd_min_nxt = setup_r;
            cd_sec_nxt = '0;
          end
        end
        VIEW_ALARM: begin
          priority if (alarm_mode_r == ALARM_ARMED) alarm_mode_nxt = ALARM_EDIT_HOUR;
          else if (alarm_mode_r == ALARM_EDIT_HOUR) alarm_mode_nxt = ALARM_EDIT_MIN;
          else if (alarm_mode_r == ALARM_EDIT_MIN) alarm_mode_nxt = ALARM_ARMED;
          else alarm_mode_nxt = alarm_mode_r;
        end
        VIEW_NONE: ;
      endcase
    end else begin
      unique case (item.view)
        VIEW_WATCH: begin
          if (!watch_run_r) begin
            watch_cnt_nxt = '0;
            watch_sec_nxt = '0;
            watch_min_nxt = '0;
          end
        end
        VIEW_TIMER: begin
          if (!cd_run_r) begin
            if (item.cmd == CMD_UP)
              setup_nxt = (setup_r >= 7'(SETUP_MAX)) ? 7'(SETUP_MAX) : setup_r + 7'd1;
            else
              setup_nxt = (setup_r <= 7'(SETUP_MIN)) ? 7'(SETUP_MIN) : setup_r - 7'd1;
          end
        end
        VIEW_ALARM: begin
          if (alarm_mode_r == ALARM_EDIT_HOUR) begin
            if (item.cmd == CMD_UP)
              alarm_hour_nxt = (alarm_hour_r == 5'(HOURS - 1)) ? '0 : alarm_hour_r + 5'd1;
            else
              alarm_hour_nxt = (alarm_hour_r == '0) ? 5'(HOURS - 1) : alarm_hour_r - 5'd1;
          end else if (alarm_mode_r == ALARM_EDIT_MIN) begin
            min_sum = {1'b0, alarm_min_r} +
                      ((item.cmd == CMD_UP) ? 7'(MIN_UP) : 7'(MIN_DN));
            alarm_min_nxt = (min_sum >= 7'(MINS)) ? 6'(min_sum - 7'(MINS)) : min_sum[5:0];
          end
        end
        VIEW_NONE: ;
      endcase
    end

    result.pulse       = pulse;
    result.pulse_kind  = !pulse ? 2'd0 :
                         (cfg.vibe_kind == VIBE_UNDEF) ? VIBE_LONG : cfg.vibe_kind;
    result.ring_source = ring_who_nxt;
    unique case (item.view)
      VIEW_WATCH: begin
        result.show_left  = watch_min_nxt;
        result.show_right = watch_sec_nxt;
        result.title_code = watch_run_nxt ? TITLE_STOP : TITLE_WATCH;
      end
      VIEW_TIMER: begin
        if (cd_run_nxt) begin
          result.show_left  = cd_min_nxt;
          result.show_right = cd_sec_nxt;
          result.title_code = TITLE_STOP;
        end else begin
          result.show_left  = setup_nxt;
          result.show_right = '0;
          result.title_code = TITLE_TIMER;
        end
      end
      VIEW_ALARM: begin
        result.show_left  = {2'b00, alarm_hour_nxt};
        result.show_right = alarm_min_nxt;
        result.title_code = (alarm_mode_nxt == ALARM_ARMED) ? TITLE_ARMED : TITLE_ALARM;
      end
      VIEW_NONE: begin
        result.show_left  = '0;
        result.show_right = '0;
        result.title_code = TITLE_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watch_run_r  <= 1'b0;
      watch_cnt_r  <= '0;
      watch_sec_r  <= '0;
      watch_min_r  <= '0;
      cd_run_r     <= 1'b0;
      cd_min_r     <= '0;
      cd_sec_r     <= '0;
      setup_r      <= SETUP_RST;
      alarm_hour_r <= ALARM_HOUR_RST;
      alarm_min_r  <= '0;
      alarm_mode_r <= ALARM_EDIT_HOUR;
      ring_left_r  <= '0;
      ring_who_r   <= RING_NONE;
      ring_phase_r <= '0;
    end else if (step) begin
      watch_run_r  <= watch_run_nxt;
      watch_cnt_r  <= watch_cnt_nxt;
      watch_sec_r  <= watch_sec_nxt;
      watch_min_r  <= watch_min_nxt;
      cd_run_r     <= cd_run_nxt;
      cd_min_r     <= cd_min_nxt;
      cd_sec_r     <= cd_sec_nxt;
      setup_r      <= setup_nxt;
      alarm_hour_r <= alarm_hour_nxt;
      alarm_min_r  <= alarm_min_nxt;
      alarm_mode_r <= alarm_mode_nxt;
      ring_left_r  <= ring_left_nxt;
      ring_who_r   <= ring_who_nxt;
      ring_phase_r <= ring_phase_nxt;
    end
  end

`ifndef SYNTHESIS
  a_who_needs_left: assert property (@(posedge clk) disable iff (!rst_n)
    ring_who_r != RING_NONE |-> ring_left_r != '0)
    else $error("ring source set with no pulses left");

  a_button_ends_ring: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && step && item.cmd != CMD_TICK && ring_left_r != '0
    |=> ring_left_r == '0 && ring_who_r == RING_NONE)
    else $error("button did not end ring");

  a_ring_start: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && step && item.cmd == CMD_TICK && ring_left_r == '0 && result.pulse
    |=> ring_left_r == $past(cfg.ring_repeats) && ring_phase_r == '0)
    else $error("ring start did not load repeat count");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_hour_r < 5'(HOURS) && alarm_min_r < 6'(MINS) &&
    watch_sec_r < 6'(SECS) && cd_sec_r < 6'(SECS) && watch_min_r <= 7'(SHOW_CAP))
    else $error("time field out of range");

  a_watch_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && step && item.cmd == CMD_TICK && !watch_run_r |=> $stable(watch_cnt_r))
    else $error("stopped stopwatch advanced");
`endif

endmodule

// File: src/stopwatch_timer_alarm_unit.sv
// Top level of the stopwatch, countdown timer and alarm unit.
//
// Input channel in_valid/in_stall/in_word: each word is a one-second tick
// carrying the local hour and minute, or an up, down or select button,
// together with the visible screen. Every accepted word yields exactly one
// result word on out_valid/out_stall/out_word: display digits, title code,
// pulse request and ring source, all taken after the word is applied.
// Configuration (pulse pattern, ring repeats) is written through
// cfg_we/cfg_idx/cfg_wdata, one register per cycle; the user must write it
// only while no word is in flight, as the block itself does not enforce this.
// A word passes the input register, then the state update and result are
// formed in one pass into the output register. Throughput is one word per
// cycle while the receiver does not stall.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more word; in_stall rises only when both
// are full. Synchronous reset clears the pipeline, sets the pulse pattern to
// long, ring repeats to 10, timer setup to 5 minutes and the alarm to 07:00
// in hour edit.
module stopwatch_timer_alarm_unit #(
  parameter int RING_INTERVAL_TICKS = swta_pkg::RING_INTERVAL_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  swta_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output swta_pkg::out_word_t                 out_word,
  input  logic                                cfg_we,
  input  logic [swta_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [swta_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import swta_pkg::*;

  cfg_t      cfg_r;
  logic      s1_valid_r, s1_valid_nxt;
  in_word_t  s1_word_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;
  out_word_t result;
  logic      out_free;
  logic      adv;
  logic      in_fire;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_free ? 1'b0 : out_valid_r);

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  swta_core #(
    .RING_INTERVAL_TICKS(RING_INTERVAL_TICKS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .item   (s1_word_r),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vibe_kind    <= VIBE_KIND_RST;
      cfg_r.ring_repeats <= RING_REPEATS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_VIBE_KIND:    cfg_r.vibe_kind    <= cfg_wdata[1:0];
        CFG_RING_REPEATS: cfg_r.ring_repeats <= cfg_wdata[3:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_word_r <= in_word;
    if (adv) out_word_r <= result;
  end

endmodule
